/* rtl/fpr_pkg.sv */
// Types and constants shared by the framed packet receiver.
`timescale 1ns / 1ps

package fpr_pkg;

   // Framing bytes on the serial link.
   localparam logic [7:0] FRAME_START = 8'h02;
   localparam logic [7:0] FRAME_END   = 8'h03;

   // Status codes reported with every result item.
   localparam logic [1:0] STATUS_WAIT  = 2'd0;
   localparam logic [1:0] STATUS_VALID = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   // Parser phase, one-hot coded.
   typedef enum logic [6:0] {
      PH_HUNT    = 7'b0000001,
      PH_LENGTH  = 7'b0000010,
      PH_PAYLOAD = 7'b0000100,
      PH_CHECK   = 7'b0001000,
      PH_TRAILER = 7'b0010000,
      PH_DONE_OK = 7'b0100000,
      PH_DONE_ERR = 7'b1000000
   } phase_type;

   // Everything the parser keeps from one byte to the next.
   typedef struct packed {
      phase_type  phase;
      logic [7:0] expected_length;
      logic [7:0] payload_count;
      logic [7:0] running_sum;
      logic [7:0] received_sum;
      logic       ready_flag;
   } parse_state_type;

   // One result item.
   typedef struct packed {
      logic [1:0] status;
      logic       frame_ready;
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [7:0] frame_length;
   } result_type;

endpackage

/* rtl/fpr_req_if.sv */
// Input channel: one received byte per item.
`timescale 1ns / 1ps

interface fpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/fpr_rsp_if.sv */
// Result channel: one status item per received byte.
`timescale 1ns / 1ps

interface fpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       frame_ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic [7:0] payload_index;
   logic [7:0] frame_length;

   modport source (output valid, output status, output frame_ready,
                   output payload_valid, output payload_byte,
                   output payload_index, output frame_length, input ready);
   modport sink   (input valid, input status, input frame_ready,
                   input payload_valid, input payload_byte,
                   input payload_index, input frame_length, output ready);
endinterface

/* rtl/framed_packet_receiver_core.sv */
// Framed packet receiver: parses STX / length / payload / checksum / ETX frames.
//
// The req channel takes one received byte per item; the rsp channel returns
// exactly one result item per byte, in order. A result carries the status
// (waiting, frame valid, frame error), the frame-ready flag, the payload byte
// with its index when the byte was payload, and the last accepted length.
// The result of a byte is registered and offered from the cycle after it is
// taken. Throughput is one byte per cycle while rsp does not stall; the whole parser
// step is a single pass of logic between the state registers and the result
// register. While a result waits, a new byte is still taken if the rsp side
// takes the waiting result in the same cycle; if rsp stalls, req.ready drops
// and the held result stays stable until it is taken. A synchronous reset
// puts the parser in the hunting phase with all counters, sums, the length
// and the ready flag cleared, and empties the result register.
`timescale 1ns / 1ps

module framed_packet_receiver_core (
   input  logic             clock,
   input  logic             reset,
   fpr_req_if.sink          req,
   fpr_rsp_if.source        rsp
);
   import fpr_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      result_ff;
   result_type      result_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            accept;

   // A byte is taken when the result register is free or being emptied.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   fpr_step u_step (
      .state      (state_ff),
      .rx_byte    (req.rx_byte),
      .state_next (state_in),
      .result     (result_in)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

   // Parser state advances once per accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase           <= PH_HUNT;
         state_ff.expected_length <= 8'd0;
         state_ff.payload_count   <= 8'd0;
         state_ff.running_sum     <= 8'd0;
         state_ff.received_sum    <= 8'd0;
         state_ff.ready_flag      <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   // Result register holds its item until the sink takes it.
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = result_ff.status;
   assign rsp.frame_ready   = result_ff.frame_ready;
   assign rsp.payload_valid = result_ff.payload_valid;
   assign rsp.payload_byte  = result_ff.payload_byte;
   assign rsp.payload_index = result_ff.payload_index;
   assign rsp.frame_length  = result_ff.frame_length;

endmodule

/* rtl/fpr_step.sv */
// Next-state and result logic of the frame parser for one received byte.
`timescale 1ns / 1ps

module fpr_step (
   input  fpr_pkg::parse_state_type state,
   input  logic [7:0]               rx_byte,
   output fpr_pkg::parse_state_type state_next,
   output fpr_pkg::result_type      result
);
   import fpr_pkg::*;

   logic [7:0] count_inc;
   logic [7:0] sum_add;

   assign count_inc = state.payload_count + 8'd1;
   assign sum_add   = state.running_sum + rx_byte;

   always_comb begin
      state_next           = state;
      result.status        = STATUS_WAIT;
      result.payload_valid = 1'b0;
      result.payload_byte  = 8'd0;
      result.payload_index = 8'd0;

      case (state.phase)
         // Look for the start byte; everything else is dropped.
         PH_HUNT: begin
            if (rx_byte == FRAME_START) begin
               state_next.phase         = PH_LENGTH;
               state_next.payload_count = 8'd0;
               state_next.running_sum   = 8'd0;
               state_next.ready_flag    = 1'b0;
            end
         end
         // A zero length is rejected and the parser hunts again.
         PH_LENGTH: begin
            if (rx_byte != 8'd0) begin
               state_next.expected_length = rx_byte;
               state_next.phase           = PH_PAYLOAD;
            end else begin
               state_next.phase = PH_HUNT;
            end
         end
         // Pass the payload byte out with its index and add it to the sum.
         PH_PAYLOAD: begin
            result.payload_valid     = 1'b1;
            result.payload_byte      = rx_byte;
            result.payload_index     = state.payload_count;
            state_next.running_sum   = sum_add;
            state_next.payload_count = count_inc;
            if (count_inc >= state.expected_length) begin
               state_next.phase = PH_CHECK;
            end
         end
         PH_CHECK: begin
            state_next.received_sum = rx_byte;
            state_next.phase        = PH_TRAILER;
         end
         // The frame is good only with the end byte and matching sums.
         PH_TRAILER: begin
            if (rx_byte == FRAME_END && state.running_sum == state.received_sum) begin
               state_next.phase      = PH_DONE_OK;
               state_next.ready_flag = 1'b1;
               result.status         = STATUS_VALID;
            end else begin
               state_next.phase = PH_DONE_ERR;
               result.status    = STATUS_ERROR;
            end
         end
         // After a result the byte is discarded and hunting restarts.
         default: begin
            state_next.phase         = PH_HUNT;
            state_next.payload_count = 8'd0;
            state_next.running_sum   = 8'd0;
            state_next.ready_flag    = 1'b0;
         end
      endcase

      result.frame_ready  = state_next.ready_flag;
      result.frame_length = state_next.expected_length;
   end

endmodule
